// ===== hdl/pacw_pkg.sv =====
`timescale 1ns / 1ps

package pacw_pkg;

  localparam int MaxVertices = 64;
  localparam int CoordBits   = 16;
  localparam int CntW        = $clog2(MaxVertices + 2);
  localparam int QDepth      = 2;

  localparam int EdgeW  = 17;
  localparam int VsumW  = 18;
  localparam int CrossW = 35;
  localparam int MagW   = 34;
  localparam int HalfW  = 17;
  localparam int SqW    = 70;
  localparam int RootW  = 35;
  localparam int RemW   = 39;
  localparam int SumW   = 60;
  localparam int AreaW  = 42;
  localparam int DenW   = 44;
  localparam int MulAW  = 36;
  localparam int MulBW  = 18;
  localparam int ProdW  = MulAW + MulBW;
  localparam int StepW  = 6;

  localparam int RootSteps = RootW;
  localparam int DivSteps  = SumW;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_DEGEN = 2'd1;
  localparam logic [1:0] ST_OVF   = 2'd2;

  typedef logic signed [15:0] coord_t;

  localparam coord_t CoordMax = coord_t'((2 ** (CoordBits - 1)) - 1);
  localparam coord_t CoordMin = coord_t'(-(2 ** (CoordBits - 1)));
  localparam logic [SumW-1:0] QPosLim = SumW'((2 ** (CoordBits - 1)) - 1);
  localparam logic [SumW-1:0] QNegLim = SumW'(2 ** (CoordBits - 1));

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } vertex_t;

  // one unit of work for the back end
  typedef struct packed {
    logic    tri_en;
    logic    last;
    logic    ovf;
    logic    few;
    vertex_t p1;
    vertex_t p2;
    vertex_t p3;
  } job_t;

endpackage

// ===== hdl/pacw_queue.sv =====
`timescale 1ns / 1ps

module pacw_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  pacw_pkg::job_t   push_data,
  output logic             full,
  input  logic             pop,
  output pacw_pkg::job_t   pop_data,
  output logic             nonempty
);

  localparam int PtrW = (pacw_pkg::QDepth > 1) ? $clog2(pacw_pkg::QDepth) : 1;
  localparam int CntQ = $clog2(pacw_pkg::QDepth + 1);

  pacw_pkg::job_t   mem_r [pacw_pkg::QDepth];
  logic [PtrW-1:0]  wr_ptr_r;
  logic [PtrW-1:0]  rd_ptr_r;
  logic [CntQ-1:0]  cnt_r;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    if (p == PtrW'(pacw_pkg::QDepth - 1)) return '0;
    return p + 1'b1;
  endfunction

  assign full     = (cnt_r == CntQ'(pacw_pkg::QDepth));
  assign nonempty = (cnt_r != '0);
  assign pop_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= ptr_inc(wr_ptr_r);
      if (pop)  rd_ptr_r <= ptr_inc(rd_ptr_r);
      if (push && !pop)      cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

// ===== hdl/pacw_front.sv =====
`timescale 1ns / 1ps

module pacw_front (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic signed [15:0]     in_vertex_x,
  input  logic signed [15:0]     in_vertex_y,
  input  logic signed [15:0]     in_vertex_z,
  input  logic                   in_last_vertex,
  input  logic                   q_full,
  output logic                   q_push,
  output pacw_pkg::job_t         q_job
);

  localparam int CB = pacw_pkg::CoordBits;

  pacw_pkg::vertex_t          anchor_r;
  pacw_pkg::vertex_t          prev_r;
  logic [pacw_pkg::CntW-1:0]  count_r;

  pacw_pkg::vertex_t          v;
  logic                       take;
  logic                       ign;
  logic                       tri_en;
  logic [pacw_pkg::CntW-1:0]  count_nxt;

  // only the low CoordBits bits carry the coordinate
  assign v.x = pacw_pkg::coord_t'(signed'(in_vertex_x[CB-1:0]));
  assign v.y = pacw_pkg::coord_t'(signed'(in_vertex_y[CB-1:0]));
  assign v.z = pacw_pkg::coord_t'(signed'(in_vertex_z[CB-1:0]));

  assign in_ready  = !q_full;
  assign take      = in_valid && in_ready;
  assign ign       = (count_r >= pacw_pkg::CntW'(pacw_pkg::MaxVertices));
  assign tri_en    = !ign && (count_r >= pacw_pkg::CntW'(2));
  assign count_nxt = ign ? pacw_pkg::CntW'(pacw_pkg::MaxVertices + 1) : count_r + 1'b1;

  always_comb begin
    q_job.tri_en = tri_en;
    q_job.last   = in_last_vertex;
    q_job.ovf    = (count_nxt > pacw_pkg::CntW'(pacw_pkg::MaxVertices));
    q_job.few    = (count_nxt < pacw_pkg::CntW'(3));
    q_job.p1     = anchor_r;
    q_job.p2     = prev_r;
    q_job.p3     = v;
  end

  // vertices that add no triangle and end nothing need no back-end work
  assign q_push = take && (tri_en || in_last_vertex);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      anchor_r <= '0;
      prev_r   <= '0;
      count_r  <= '0;
    end else if (take) begin
      if (in_last_vertex) begin
        anchor_r <= '0;
        prev_r   <= '0;
        count_r  <= '0;
      end else begin
        if (!ign && count_r == '0) anchor_r <= v;
        if (!ign && count_r != '0) prev_r   <= v;
        count_r <= count_nxt;
      end
    end
  end

endmodule

// ===== hdl/pacw_back.sv =====
`timescale 1ns / 1ps

module pacw_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_nonempty,
  input  pacw_pkg::job_t      q_job,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [15:0]  out_centroid_x,
  output logic signed [15:0]  out_centroid_y,
  output logic signed [15:0]  out_centroid_z,
  output logic [1:0]          out_status
);

  localparam int EdgeW  = pacw_pkg::EdgeW;
  localparam int VsumW  = pacw_pkg::VsumW;
  localparam int CrossW = pacw_pkg::CrossW;
  localparam int MagW   = pacw_pkg::MagW;
  localparam int HalfW  = pacw_pkg::HalfW;
  localparam int SqW    = pacw_pkg::SqW;
  localparam int RootW  = pacw_pkg::RootW;
  localparam int RemW   = pacw_pkg::RemW;
  localparam int SumW   = pacw_pkg::SumW;
  localparam int AreaW  = pacw_pkg::AreaW;
  localparam int DenW   = pacw_pkg::DenW;
  localparam int MulAW  = pacw_pkg::MulAW;
  localparam int MulBW  = pacw_pkg::MulBW;
  localparam int ProdW  = pacw_pkg::ProdW;
  localparam int StepW  = pacw_pkg::StepW;

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_SQRT, S_WGT, S_FIN, S_DIV, S_OUT
  } state_t;

  state_t                     state_r;
  pacw_pkg::job_t             job_r;
  logic signed [EdgeW-1:0]    e1_r [3];
  logic signed [EdgeW-1:0]    e2_r [3];
  logic signed [VsumW-1:0]    vs_r [3];
  logic signed [CrossW-1:0]   c_r  [3];
  logic [SqW-1:0]             n_r;
  logic [StepW-1:0]           step_r;
  logic [RemW-1:0]            rem_r;
  logic [RootW-1:0]           root_r;
  logic signed [ProdW-1:0]    prod_r;
  logic signed [SumW-1:0]     wsum_r [3];
  logic [AreaW-1:0]           area_r;
  logic [DenW-1:0]            den_r;
  logic [SumW-1:0]            q_r;
  logic [DenW:0]              drem_r;
  logic [1:0]                 ax_r;
  logic                       neg_r;
  pacw_pkg::coord_t           res_r [3];
  logic [1:0]                 status_r;
  logic                       out_valid_r;

  logic [MagW-1:0]            cmag [3];
  logic signed [MulAW-1:0]    mul_a;
  logic signed [MulBW-1:0]    mul_b;
  logic signed [ProdW-1:0]    prod_w;
  logic [RemW-1:0]            rem_sh;
  logic [RemW-1:0]            trial;
  logic [DenW:0]              drem_sh;
  logic [3:0]                 pidx;
  logic [1:0]                 widx;
  logic [SumW-1:0]            wmag [3];
  pacw_pkg::coord_t           sat_q;
  logic                       out_free;

  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || out_ready;
  assign q_pop     = (state_r == S_IDLE) && q_nonempty;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cmag[i] = c_r[i][CrossW-1] ? MagW'(-c_r[i]) : MagW'(c_r[i]);
      wmag[i] = wsum_r[i][SumW-1] ? SumW'(0) - SumW'(wsum_r[i]) : SumW'(wsum_r[i]);
    end
  end

  // shared multiplier operand selection
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_r == S_WGT) begin
      mul_a = signed'(MulAW'(root_r));
      case (step_r)
        6'd0:    mul_b = vs_r[0];
        6'd1:    mul_b = vs_r[1];
        default: mul_b = vs_r[2];
      endcase
    end else begin
      case (step_r)
        6'd0:  begin mul_a = MulAW'(e1_r[1]); mul_b = MulBW'(e2_r[2]); end
        6'd1:  begin mul_a = MulAW'(e1_r[2]); mul_b = MulBW'(e2_r[1]); end
        6'd2:  begin mul_a = MulAW'(e1_r[2]); mul_b = MulBW'(e2_r[0]); end
        6'd3:  begin mul_a = MulAW'(e1_r[0]); mul_b = MulBW'(e2_r[2]); end
        6'd4:  begin mul_a = MulAW'(e1_r[0]); mul_b = MulBW'(e2_r[1]); end
        6'd5:  begin mul_a = MulAW'(e1_r[1]); mul_b = MulBW'(e2_r[0]); end
        6'd6:  begin
          mul_a = signed'(MulAW'(cmag[0][MagW-1:HalfW]));
          mul_b = signed'(MulBW'(cmag[0][MagW-1:HalfW]));
        end
        6'd7:  begin
          mul_a = signed'(MulAW'(cmag[0][MagW-1:HalfW]));
          mul_b = signed'(MulBW'(cmag[0][HalfW-1:0]));
        end
        6'd8:  begin
          mul_a = signed'(MulAW'(cmag[0][HalfW-1:0]));
          mul_b = signed'(MulBW'(cmag[0][HalfW-1:0]));
        end
        6'd9:  begin
          mul_a = signed'(MulAW'(cmag[1][MagW-1:HalfW]));
          mul_b = signed'(MulBW'(cmag[1][MagW-1:HalfW]));
        end
        6'd10: begin
          mul_a = signed'(MulAW'(cmag[1][MagW-1:HalfW]));
          mul_b = signed'(MulBW'(cmag[1][HalfW-1:0]));
        end
        6'd11: begin
          mul_a = signed'(MulAW'(cmag[1][HalfW-1:0]));
          mul_b = signed'(MulBW'(cmag[1][HalfW-1:0]));
        end
        6'd12: begin
          mul_a = signed'(MulAW'(cmag[2][MagW-1:HalfW]));
          mul_b = signed'(MulBW'(cmag[2][MagW-1:HalfW]));
        end
        6'd13: begin
          mul_a = signed'(MulAW'(cmag[2][MagW-1:HalfW]));
          mul_b = signed'(MulBW'(cmag[2][HalfW-1:0]));
        end
        6'd14: begin
          mul_a = signed'(MulAW'(cmag[2][HalfW-1:0]));
          mul_b = signed'(MulBW'(cmag[2][HalfW-1:0]));
        end
        default: begin
          mul_a = '0;
          mul_b = '0;
        end
      endcase
    end
  end

  assign prod_w  = mul_a * mul_b;
  assign pidx    = 4'(step_r - 6'd1);
  assign widx    = 2'(step_r - 6'd1);

  // square root: one result bit per cycle
  assign rem_sh  = {rem_r[RemW-3:0], n_r[SqW-1:SqW-2]};
  assign trial   = RemW'({root_r, 2'b01});
  // divider: one quotient bit per cycle
  assign drem_sh = {drem_r[DenW-1:0], q_r[SumW-1]};

  always_comb begin
    if (!neg_r) begin
      sat_q = (q_r > pacw_pkg::QPosLim) ? pacw_pkg::CoordMax : pacw_pkg::coord_t'(q_r[15:0]);
    end else begin
      sat_q = (q_r > pacw_pkg::QNegLim) ? pacw_pkg::CoordMin
                                        : pacw_pkg::coord_t'(16'd0 - q_r[15:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      area_r      <= '0;
      for (int i = 0; i < 3; i++) wsum_r[i] <= '0;
    end else begin
      // S_OUT decides out_valid_r itself when it hands over a result
      if (out_valid_r && out_ready && state_r != S_OUT) out_valid_r <= 1'b0;
      prod_r <= prod_w;
      unique case (state_r)
        S_IDLE: begin
          if (q_nonempty) begin
            job_r <= q_job;
            e1_r[0] <= EdgeW'(q_job.p3.x) - EdgeW'(q_job.p1.x);
            e1_r[1] <= EdgeW'(q_job.p3.y) - EdgeW'(q_job.p1.y);
            e1_r[2] <= EdgeW'(q_job.p3.z) - EdgeW'(q_job.p1.z);
            e2_r[0] <= EdgeW'(q_job.p3.x) - EdgeW'(q_job.p2.x);
            e2_r[1] <= EdgeW'(q_job.p3.y) - EdgeW'(q_job.p2.y);
            e2_r[2] <= EdgeW'(q_job.p3.z) - EdgeW'(q_job.p2.z);
            vs_r[0] <= VsumW'(q_job.p1.x) + VsumW'(q_job.p2.x) + VsumW'(q_job.p3.x);
            vs_r[1] <= VsumW'(q_job.p1.y) + VsumW'(q_job.p2.y) + VsumW'(q_job.p3.y);
            vs_r[2] <= VsumW'(q_job.p1.z) + VsumW'(q_job.p2.z) + VsumW'(q_job.p3.z);
            n_r     <= '0;
            step_r  <= '0;
            state_r <= q_job.tri_en ? S_MUL : S_FIN;
          end
        end
        S_MUL: begin
          // product issued last cycle lands in prod_r now
          if (step_r != '0) begin
            case (pidx)
              4'd0: c_r[0] <= CrossW'(prod_r);
              4'd1: c_r[0] <= c_r[0] - CrossW'(prod_r);
              4'd2: c_r[1] <= CrossW'(prod_r);
              4'd3: c_r[1] <= c_r[1] - CrossW'(prod_r);
              4'd4: c_r[2] <= CrossW'(prod_r);
              4'd5: c_r[2] <= c_r[2] - CrossW'(prod_r);
              4'd6, 4'd9, 4'd12:
                n_r <= n_r + (SqW'(prod_r[2*HalfW-1:0]) << (2 * HalfW));
              4'd7, 4'd10, 4'd13:
                n_r <= n_r + (SqW'(prod_r[2*HalfW-1:0]) << (HalfW + 1));
              default:
                n_r <= n_r + SqW'(prod_r[2*HalfW-1:0]);
            endcase
          end
          if (step_r == 6'd15) begin
            rem_r   <= '0;
            root_r  <= '0;
            step_r  <= '0;
            state_r <= S_SQRT;
          end else begin
            step_r <= step_r + 1'b1;
          end
        end
        S_SQRT: begin
          n_r <= n_r << 2;
          if (rem_sh >= trial) begin
            rem_r  <= rem_sh - trial;
            root_r <= {root_r[RootW-2:0], 1'b1};
          end else begin
            rem_r  <= rem_sh;
            root_r <= {root_r[RootW-2:0], 1'b0};
          end
          if (step_r == StepW'(pacw_pkg::RootSteps - 1)) begin
            step_r  <= '0;
            state_r <= S_WGT;
          end else begin
            step_r <= step_r + 1'b1;
          end
        end
        S_WGT: begin
          if (step_r != '0) wsum_r[widx] <= wsum_r[widx] + SumW'(prod_r);
          if (step_r == 6'd3) begin
            area_r  <= area_r + AreaW'(root_r);
            state_r <= job_r.last ? S_FIN : S_IDLE;
          end else begin
            step_r <= step_r + 1'b1;
          end
        end
        S_FIN: begin
          for (int i = 0; i < 3; i++) res_r[i] <= '0;
          if (job_r.ovf) begin
            status_r <= pacw_pkg::ST_OVF;
            state_r  <= S_OUT;
          end else if (job_r.few || area_r == '0) begin
            status_r <= pacw_pkg::ST_DEGEN;
            state_r  <= S_OUT;
          end else begin
            status_r <= pacw_pkg::ST_OK;
            den_r    <= DenW'(area_r) + DenW'({area_r, 1'b0});
            ax_r     <= '0;
            neg_r    <= wsum_r[0][SumW-1];
            q_r      <= wmag[0];
            drem_r   <= '0;
            step_r   <= '0;
            state_r  <= S_DIV;
          end
        end
        S_DIV: begin
          if (step_r == StepW'(pacw_pkg::DivSteps)) begin
            res_r[ax_r] <= sat_q;
            step_r      <= '0;
            drem_r      <= '0;
            if (ax_r == 2'd2) begin
              state_r <= S_OUT;
            end else begin
              ax_r  <= ax_r + 1'b1;
              neg_r <= wsum_r[ax_r + 1'b1][SumW-1];
              q_r   <= wmag[ax_r + 1'b1];
            end
          end else begin
            if (drem_sh >= {1'b0, den_r}) begin
              drem_r <= drem_sh - {1'b0, den_r};
              q_r    <= {q_r[SumW-2:0], 1'b1};
            end else begin
              drem_r <= drem_sh;
              q_r    <= {q_r[SumW-2:0], 1'b0};
            end
            step_r <= step_r + 1'b1;
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_centroid_x <= res_r[0];
            out_centroid_y <= res_r[1];
            out_centroid_z <= res_r[2];
            out_status     <= status_r;
            out_valid_r    <= 1'b1;
            area_r         <= '0;
            for (int i = 0; i < 3; i++) wsum_r[i] <= '0;
            state_r        <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== hdl/polygon_area_weighted_centroid.sv =====
`timescale 1ns / 1ps
// channel | ports                                            | transfer
// in      | in_vertex_x/y/z, in_last_vertex                  | in_valid & in_ready
// out     | out_centroid_x/y/z, out_status                   | out_valid & out_ready
//
// A vertex that only sets up the fan needs no back-end work. A vertex that closes a
// triangle goes through the back end: 15 products on one shared 36x18
// multiplier, a bit-serial square root and 3 weighting products. For a good
// polygon the last vertex adds three bit-serial divides.
// A two-entry queue sits between front and back; in_ready drops when it fills.
// Reset (synchronous, rst_n low) clears the fan state, sums and the queue.

module polygon_area_weighted_centroid (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_vertex_x,
  input  logic signed [15:0] in_vertex_y,
  input  logic signed [15:0] in_vertex_z,
  input  logic               in_last_vertex,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_centroid_x,
  output logic signed [15:0] out_centroid_y,
  output logic signed [15:0] out_centroid_z,
  output logic [1:0]         out_status
);

  logic           q_full;
  logic           q_push;
  logic           q_pop;
  logic           q_nonempty;
  pacw_pkg::job_t push_job;
  pacw_pkg::job_t pop_job;

  pacw_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_vertex_x    (in_vertex_x),
    .in_vertex_y    (in_vertex_y),
    .in_vertex_z    (in_vertex_z),
    .in_last_vertex (in_last_vertex),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_job          (push_job)
  );

  pacw_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (push_job),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (pop_job),
    .nonempty  (q_nonempty)
  );

  pacw_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_nonempty     (q_nonempty),
    .q_job          (pop_job),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_centroid_x (out_centroid_x),
    .out_centroid_y (out_centroid_y),
    .out_centroid_z (out_centroid_z),
    .out_status     (out_status)
  );

endmodule

// ===== hdl/pacw_checker.sv =====
`timescale 1ns / 1ps

module pacw_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [15:0] out_centroid_x,
  input logic signed [15:0] out_centroid_y,
  input logic signed [15:0] out_centroid_z,
  input logic [1:0]         out_status
);

  // a result waiting on the sink keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_centroid_x) &&
      $stable(out_centroid_y) && $stable(out_centroid_z) && $stable(out_status))
    else $error("result changed while stalled");

  // failed polygons carry a zero centroid
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != pacw_pkg::ST_OK |->
      out_centroid_x == 16'sd0 && out_centroid_y == 16'sd0 && out_centroid_z == 16'sd0)
    else $error("non-zero centroid with error status");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

  a_ready_after_reset: assert property (@(posedge clk)
    !rst_n |=> in_ready)
    else $error("input not ready after reset");

endmodule

bind polygon_area_weighted_centroid pacw_checker u_pacw_checker (.*);

// ===== tb/polygon_area_weighted_centroid_tb.sv =====
`timescale 1ns / 1ps

module polygon_area_weighted_centroid_tb;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic [1:0]         st;
  } centroid_t;

  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic               last;
    bit                 has_exp; // typed-in expectation present
    centroid_t          exp;
  } vrow_t;

  logic clk;
  logic rst_n;
  logic in_valid, in_ready;
  logic signed [15:0] in_vertex_x, in_vertex_y, in_vertex_z;
  logic in_last_vertex;
  logic out_valid, out_ready;
  logic signed [15:0] out_centroid_x, out_centroid_y, out_centroid_z;
  logic [1:0] out_status;

  polygon_area_weighted_centroid u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_vertex_x(in_vertex_x), .in_vertex_y(in_vertex_y),
    .in_vertex_z(in_vertex_z), .in_last_vertex(in_last_vertex),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_centroid_x(out_centroid_x), .out_centroid_y(out_centroid_y),
    .out_centroid_z(out_centroid_z), .out_status(out_status)
  );

  // predictor state
  longint signed anchor_v[3];
  longint signed prev_v[3];
  int            vcount;
  longint signed wsum[3];
  longint signed area_acc;

  centroid_t expected_q[$];
  int errors;
  int n_results, n_sent;
  int n_ok, n_degen, n_ovf;
  bit no_idle;
  bit hold_rx;

  task automatic report_error(input string msg);
    $display("mismatch %s (result %0d)", msg, n_results);
    errors++;
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    report_error($sformatf("%s: got %0d want %0d", what, got, want));
  endtask

  function automatic void clear_fan();
    for (int i = 0; i < 3; i++) begin
      anchor_v[i] = 0;
      prev_v[i] = 0;
      wsum[i] = 0;
    end
    vcount = 0;
    area_acc = 0;
  endfunction

  // floor(sqrt(n)) of a 70-bit value
  function automatic longint unsigned root_floor(logic [69:0] n);
    logic [34:0] r;
    logic [69:0] c;
    r = '0;
    for (int b = 34; b >= 0; b--) begin
      c = 70'(r | (35'd1 << b));
      if (c * c <= n) r = r | (35'd1 << b);
    end
    return longint'(r);
  endfunction

  function automatic logic signed [15:0] sat_coord(longint signed v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return -16'sd32768;
    return 16'(v);
  endfunction

  function automatic bit centroid_step(input logic signed [15:0] x, y, z,
                                       input logic last, output centroid_t res);
    longint signed v[3], e1[3], e2[3], c[3], d, den;
    logic [69:0] sq;
    v[0] = x; v[1] = y; v[2] = z;
    if (vcount >= pacw_pkg::MaxVertices) begin
      vcount = pacw_pkg::MaxVertices + 1;
    end else begin
      if (vcount == 0) begin
        for (int i = 0; i < 3; i++) anchor_v[i] = v[i];
      end else if (vcount >= 2) begin
        for (int i = 0; i < 3; i++) begin
          e1[i] = v[i] - anchor_v[i];
          e2[i] = v[i] - prev_v[i];
        end
        c[0] = e1[1] * e2[2] - e1[2] * e2[1];
        c[1] = e1[2] * e2[0] - e1[0] * e2[2];
        c[2] = e1[0] * e2[1] - e1[1] * e2[0];
        sq = '0;
        for (int i = 0; i < 3; i++) begin
          logic [69:0] m;
          m = 70'(c[i] < 0 ? -c[i] : c[i]);
          sq = sq + m * m;
        end
        d = longint'(root_floor(sq));
        for (int i = 0; i < 3; i++) wsum[i] += d * (anchor_v[i] + prev_v[i] + v[i]);
        area_acc += d;
      end
      if (vcount >= 1) for (int i = 0; i < 3; i++) prev_v[i] = v[i];
      vcount++;
    end
    if (!last) return 0;
    res.x = 0; res.y = 0; res.z = 0;
    if (vcount > pacw_pkg::MaxVertices) begin
      res.st = pacw_pkg::ST_OVF;
    end else if (vcount < 3 || area_acc == 0) begin
      res.st = pacw_pkg::ST_DEGEN;
    end else begin
      den = area_acc * 3;
      res.x = sat_coord(wsum[0] / den);
      res.y = sat_coord(wsum[1] / den);
      res.z = sat_coord(wsum[2] / den);
      res.st = pacw_pkg::ST_OK;
    end
    clear_fan();
    return 1;
  endfunction

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #100ms;
    $display("timeout");
    $display("TB_ERROR");
    $finish;
  end

  // result side
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          report_error("unexpected result");
        end else begin
          centroid_t e;
          e = expected_q.pop_front();
          if (out_centroid_x !== e.x) report_mismatch("centroid_x", out_centroid_x, e.x);
          if (out_centroid_y !== e.y) report_mismatch("centroid_y", out_centroid_y, e.y);
          if (out_centroid_z !== e.z) report_mismatch("centroid_z", out_centroid_z, e.z);
          if (out_status !== e.st) report_mismatch("status", out_status, e.st);
          case (e.st)
            pacw_pkg::ST_OK:    n_ok++;
            pacw_pkg::ST_DEGEN: n_degen++;
            default:            n_ovf++;
          endcase
        end
        n_results++;
      end
      out_ready <= !hold_rx && (no_idle || $urandom_range(99) >= 15);
    end
  end

  // long hold-off on the receiver, counted here
  initial begin
    hold_rx = 1'b0;
    wait (n_sent >= 300);
    @(posedge clk);
    hold_rx = 1'b1;
    repeat (3000) @(posedge clk);
    hold_rx = 1'b0;
  end

  vrow_t stim[$];

  function automatic vrow_t mk(int x, int y, int z, bit last);
    vrow_t r;
    r.x = 16'(x); r.y = 16'(y); r.z = 16'(z); r.last = last; r.has_exp = 0;
    return r;
  endfunction

  function automatic vrow_t mk_exp(int x, int y, int z, bit last, logic [1:0] st);
    vrow_t r;
    r = mk(x, y, z, last);
    r.has_exp = 1;
    r.exp.x = 0; r.exp.y = 0; r.exp.z = 0; r.exp.st = st;
    return r;
  endfunction

  function automatic logic signed [15:0] rnd_coord(int mode);
    case (mode)
      0: return 16'($urandom);
      1: return 16'($urandom_range(64) - 32);
      default: return ($urandom_range(1) ? 16'sh7fff : -16'sh8000) - 16'($urandom_range(3));
    endcase
  endfunction

  // one random polygon: mostly points on a tilted circle, random extent; else random or extreme coords
  task automatic add_polygon(int nv);
    int cx, cy, cz, rad, mode;
    mode = $urandom_range(9);
    cx = $signed(16'($urandom)) / 2; cy = $signed(16'($urandom)) / 2;
    cz = $signed(16'($urandom)) / 2;
    rad = $urandom_range(1, 16000);
    for (int i = 0; i < nv; i++) begin
      real a;
      vrow_t r;
      a = 6.2831853 * i / nv;
      if (mode == 0) begin
        r = mk(rnd_coord(0), rnd_coord(0), rnd_coord(0), i == nv - 1);
      end else if (mode == 1) begin
        r = mk(rnd_coord(2), rnd_coord(2), rnd_coord(1), i == nv - 1);
      end else begin
        r = mk(cx + int'(rad * $cos(a)), cy + int'(rad * $sin(a)),
               cz + int'(rad * $cos(a) / 3), i == nv - 1);
      end
      stim.push_back(r);
    end
  endtask

  initial begin
    centroid_t res;
    int k, nv;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_vertex_x = '0; in_vertex_y = '0; in_vertex_z = '0;
    in_last_vertex = 1'b0;
    no_idle = 1'b0;
    errors = 0; n_results = 0; n_sent = 0;
    n_ok = 0; n_degen = 0; n_ovf = 0;
    clear_fan();

    // directed: single vertex, two vertices, collinear, small triangle, extremes, overflow, 64 vertices
    stim.push_back(mk_exp(5, 6, 7, 1, pacw_pkg::ST_DEGEN));
    stim.push_back(mk(-32768, -32768, -32768, 0));
    stim.push_back(mk_exp(32767, 32767, 32767, 1, pacw_pkg::ST_DEGEN));
    stim.push_back(mk(0, 0, 0, 0));
    stim.push_back(mk(4, 4, 4, 0));
    stim.push_back(mk_exp(8, 8, 8, 1, pacw_pkg::ST_DEGEN));
    stim.push_back(mk(0, 0, 0, 0));
    stim.push_back(mk(12, 0, 0, 0));
    stim.push_back(mk(0, 12, 0, 1));
    stim.push_back(mk(-32768, -32768, -32768, 0));
    stim.push_back(mk(32767, -32768, 32767, 0));
    stim.push_back(mk(32767, 32767, -32768, 0));
    stim.push_back(mk(-32768, 32767, 32767, 1));
    stim.push_back(mk(32767, 32767, 32767, 0));
    stim.push_back(mk(-32768, 0, 0, 0));
    stim.push_back(mk(0, -32768, 0, 1));
    for (int i = 0; i < 66; i++)
      stim.push_back(i == 65 ? mk_exp(i, i * 3, 0, 1, pacw_pkg::ST_OVF)
                             : mk(i, (i * 7) % 50, i % 3, 0));
    for (int i = 0; i < 64; i++)
      stim.push_back(mk(100 * (i % 2), 100 * (i / 2), i % 5, i == 63));

    while (stim.size() < 1700) begin
      k = $urandom_range(99);
      if (k < 80) nv = $urandom_range(3, 8);
      else if (k < 88) nv = $urandom_range(1, 2);
      else if (k < 96) nv = $urandom_range(9, 30);
      else nv = $urandom_range(60, 70);
      add_polygon(nv);
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    k = 0;
    while (k < stim.size()) begin
      @(posedge clk);
      if (in_valid && in_ready) k++;
      if (k >= 400 && k < 700) no_idle = 1'b1;
      else no_idle = 1'b0;
      if (k < stim.size() && (no_idle || in_valid && !in_ready ||
                              $urandom_range(99) >= 15)) begin
        if (!(in_valid && !in_ready)) begin
          vrow_t r;
          r = stim[k];
          if (centroid_step(r.x, r.y, r.z, r.last, res)) begin
            if (r.has_exp && res != r.exp) begin
              report_error($sformatf("typed-in expectation disagrees at row %0d", k));
            end
            expected_q.push_back(res);
          end
          in_vertex_x <= r.x; in_vertex_y <= r.y; in_vertex_z <= r.z;
          in_last_vertex <= r.last;
          n_sent = k + 1;
        end
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
    in_valid <= 1'b0;

    while (expected_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);

    $display("%0d vertices sent, %0d centroids checked: %0d ok, %0d degenerate, %0d overflow",
             stim.size(), n_results, n_ok, n_degen, n_ovf);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== polygon_area_weighted_centroid.f =====
hdl/pacw_pkg.sv
hdl/pacw_queue.sv
hdl/pacw_front.sv
hdl/pacw_back.sv
hdl/polygon_area_weighted_centroid.sv
hdl/pacw_checker.sv
tb/polygon_area_weighted_centroid_tb.sv
